FILE: rtl/dtsf_pkg.sv
// shared constants, widths and types of the die temperature smoothing filter
// used by dtsf_div and die_temperature_smoothing_filter; no dependencies
package dtsf_pkg;

  localparam int RAW_W  = 10;
  localparam int OUT_W  = 13;
  localparam int THR_W  = 12;
  localparam int FAC_W  = 8;
  localparam int CNT_W  = 8;
  localparam int SCL_W  = 22;
  localparam int PROD_W = 21;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  localparam int DIV_W     = 22;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITERS = DIV_W / DIV_STEPS;
  localparam int DIV_CW    = $clog2(DIV_ITERS);

  localparam logic signed [PROD_W-1:0] RAW_OFFSET = 21'sd605;
  localparam logic signed [PROD_W-1:0] CONV_MUL   = 21'sd1000;
  localparam logic [FAC_W-1:0]         CONV_DIV   = 8'd205;

  localparam logic signed [DIV_W-1:0] OUT_MIN = -22'sd2951;
  localparam logic signed [DIV_W-1:0] OUT_MAX = 22'sd2039;

  localparam logic [THR_W-1:0] THR_RESET = 12'd20;
  localparam logic [FAC_W-1:0] FAC_RESET = 8'd10;
  localparam logic [CNT_W-1:0] SPU_RESET = 8'd3;

  localparam logic [CFG_AW-1:0] REG_JUMP_THR = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FACTOR   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SPU      = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic             neg;
    logic [FAC_W-1:0] divisor;
  } dtsf_div_req_t;

endpackage

FILE: rtl/dtsf_div.sv
// shared sign-magnitude restoring divider, two quotient bits per cycle
// depends on dtsf_pkg
module dtsf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dtsf_pkg::dtsf_div_req_t             req_i,
  output logic                                busy_o,
  output logic signed [dtsf_pkg::DIV_W-1:0]   quot_o
);
  import dtsf_pkg::*;

  localparam logic [DIV_CW-1:0] DivLast = DIV_CW'(DIV_ITERS - 1);

  logic              busy_q, busy_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [FAC_W-1:0]  rem_q, rem_d;
  logic [FAC_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic [DIV_W-1:0]  step_num;
  logic [FAC_W-1:0]  step_rem;

  // two dependent compare and subtract steps
  always_comb begin
    logic [FAC_W:0]   t;
    logic [FAC_W-1:0] r;
    logic [DIV_W-1:0] n;
    r = rem_q;
    n = num_q;
    t = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, n[DIV_W-1]};
      n = {n[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t = t - {1'b0, den_q};
        n[0] = 1'b1;
      end
      r = t[FAC_W-1:0];
    end
    step_num = n;
    step_rem = r;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      num_d = step_num;
      rem_d = step_rem;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == DivLast |=> !busy_q)
    else $error("divider ran past its last iteration");

endmodule

FILE: rtl/die_temperature_smoothing_filter.sv
// Die temperature smoothing filter: converts each raw 10-bit sensor reading to signed
// tenths of a degree, ((raw - 605) * 1000) / 205 truncated toward zero, and runs it
// through an exponential moving average kept scaled by the smoothing factor. A sample
// that deviates by more than jump_threshold * factor replaces the average outright.
// After every samples_per_update samples one filtered temperature item is emitted,
// saturated to -2951..2039. Each sample goes through the single shared divider, which
// resolves two quotient bits per cycle and serves the conversion, the smoothing step and
// the output scaling in turn; the input is not ready until the sample is through. Every
// sample takes the conversion division, one that does not jump also the smoothing
// division, and one that emits an item also the output scaling division. An
// output item waiting at the master side does not hold off the next sample; a sample
// with an item of its own to emit then waits, input not ready, until the output
// register frees. Configuration writes are taken every cycle and are meant for an idle
// block.
// depends on dtsf_pkg and dtsf_div
module die_temperature_smoothing_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtsf_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [dtsf_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [9:0] raw_reading
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata    // [12:0] temperature_tenths
);
  import dtsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_TGT, S_CMP, S_UPD, S_CNT, S_OUT
  } state_e;

  state_e state_q;

  logic [THR_W-1:0] thr_q;
  logic [FAC_W-1:0] fac_q;
  logic [CNT_W-1:0] spu_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [OUT_W-1:0]  tenths_q;
  logic signed [SCL_W-1:0]  target_q;
  logic [SCL_W-1:0]         limit_q;
  logic [DIV_W-1:0]         diff_mag_q;
  logic                     diff_neg_q;
  logic signed [SCL_W-1:0]  scaled_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     go_q;
  logic                     m_valid_q;
  logic signed [OUT_W-1:0]  m_data_q;

  logic                     in_acc;
  logic [FAC_W-1:0]         f_eff;
  logic [CNT_W-1:0]         need;
  logic signed [PROD_W-1:0] raw_off;
  logic [DIV_W-1:0]         prod_mag;
  logic [DIV_W-1:0]         scaled_mag;
  logic signed [SCL_W:0]    diff;
  logic [SCL_W:0]           diff_mag;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DIV_W-1:0]  quot;
  logic signed [DIV_W-1:0]  quot_sat;
  logic                     out_free;
  dtsf_div_req_t            div_req;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign f_eff   = (fac_q == '0) ? FAC_W'(1) : fac_q;
  assign need    = (spu_q == '0) ? CNT_W'(1) : spu_q;
  assign raw_off = $signed({{(PROD_W-RAW_W){1'b0}}, s_axis_tdata[RAW_W-1:0]}) - RAW_OFFSET;

  assign prod_mag   = {1'b0, prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q)};
  assign scaled_mag = scaled_q[SCL_W-1] ? DIV_W'(-scaled_q) : DIV_W'(scaled_q);
  assign diff       = $signed({target_q[SCL_W-1], target_q})
                    - $signed({scaled_q[SCL_W-1], scaled_q});
  assign diff_mag   = diff[SCL_W] ? (SCL_W+1)'(-diff) : (SCL_W+1)'(diff);
  assign cnt_inc    = cnt_q + 1'b1;
  assign div_done   = !go_q && !div_busy;
  assign out_free   = !m_valid_q || m_axis_tready;

  always_comb begin
    if (quot < OUT_MIN) begin
      quot_sat = OUT_MIN;
    end else if (quot > OUT_MAX) begin
      quot_sat = OUT_MAX;
    end else begin
      quot_sat = quot;
    end
  end

  always_comb begin
    div_req       = '0;
    div_req.start = go_q;
    unique case (state_q)
      S_CONV: begin
        div_req.dividend = prod_mag;
        div_req.neg      = prod_q[PROD_W-1];
        div_req.divisor  = CONV_DIV;
      end
      S_UPD: begin
        div_req.dividend = diff_mag_q;
        div_req.neg      = diff_neg_q;
        div_req.divisor  = f_eff;
      end
      S_OUT: begin
        div_req.dividend = scaled_mag;
        div_req.neg      = scaled_q[SCL_W-1];
        div_req.divisor  = f_eff;
      end
      default: begin
        div_req.dividend = '0;
      end
    endcase
  end

  dtsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      fac_q <= FAC_RESET;
      spu_q <= SPU_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_JUMP_THR: thr_q <= cfg_data_i[THR_W-1:0];
        REG_FACTOR:   fac_q <= cfg_data_i[FAC_W-1:0];
        REG_SPU:      spu_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scaled_q   <= '0;
      cnt_q      <= '0;
      go_q       <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      prod_q     <= '0;
      tenths_q   <= '0;
      target_q   <= '0;
      limit_q    <= '0;
      diff_mag_q <= '0;
      diff_neg_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prod_q  <= raw_off * CONV_MUL;
            go_q    <= 1'b1;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (div_done) begin
            tenths_q <= quot[OUT_W-1:0];
            state_q  <= S_TGT;
          end
        end
        S_TGT: begin
          target_q <= $signed({{(SCL_W-OUT_W){tenths_q[OUT_W-1]}}, tenths_q})
                    * $signed({{(SCL_W-FAC_W){1'b0}}, f_eff});
          limit_q  <= {{(SCL_W-THR_W){1'b0}}, thr_q} * {{(SCL_W-FAC_W){1'b0}}, f_eff};
          state_q  <= S_CMP;
        end
        S_CMP: begin
          if (diff_mag > {1'b0, limit_q}) begin
            scaled_q <= target_q;
            state_q  <= S_CNT;
          end else begin
            diff_mag_q <= diff_mag[DIV_W-1:0];
            diff_neg_q <= diff[SCL_W];
            go_q       <= 1'b1;
            state_q    <= S_UPD;
          end
        end
        S_UPD: begin
          if (div_done) begin
            scaled_q <= scaled_q + quot;
            state_q  <= S_CNT;
          end
        end
        S_CNT: begin
          if (cnt_inc < need) begin
            cnt_q   <= cnt_inc;
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= '0;
            go_q    <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (div_done && out_free) begin
            m_data_q  <= quot_sat[OUT_W-1:0];
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(16-OUT_W){1'b0}}, m_data_q};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("sample accepted while previous one still in work");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q >= $signed(OUT_MIN[OUT_W-1:0]))
               && (m_data_q <= $signed(OUT_MAX[OUT_W-1:0])))
    else $error("output temperature outside saturation range");

  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (state_q == S_CONV) || (state_q == S_UPD) || (state_q == S_OUT))
    else $error("divider started outside a divide step");

endmodule
